@@ hw/rtl/magnetometer_iron_calibration_macros.svh @@
// Assertion macros for the magnetometer iron calibration block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MAGNETOMETER_IRON_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_IRON_CALIBRATION_MACROS_SVH

// Same-cycle implication under clock and active-low reset.
`define MIC_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("mic assertion failed");

// Next-cycle implication under clock and active-low reset.
`define MIC_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("mic assertion failed");

`endif

@@ hw/rtl/mic_pkg.sv @@
// Shared types and constants for the magnetometer iron calibration block.
// No dependencies; used by every module of the block.
package mic_pkg;

	localparam int RawW = 16;
	localparam int CoefW = 16;
	localparam int DiffW = 17;
	localparam int ProdW = 33;
	localparam int AccW = 35;
	localparam int QuotW = 23;
	localparam int OutW = 20;
	localparam int RegIdxW = 3;
	localparam int RegDataW = 48;

	// acc / 30720 = (acc / 2048) / 15, rounded half away from zero
	localparam int ScaleShift = 11;
	localparam logic [AccW-1:0] RoundBias = AccW'(15360);
	localparam int RecipW = 24;
	localparam logic [RecipW-1:0] Recip15 = 24'd8947849;
	localparam int RecipShift = 27;
	localparam int RecipProdW = QuotW + RecipW;

	localparam logic [OutW-1:0] OutMaxMag = 20'd524287;
	localparam logic [OutW:0] OutMinMag = 21'd524288;

	localparam logic [RegIdxW-1:0] REG_MATRIX_XX = 3'd0;
	localparam logic [RegIdxW-1:0] REG_MATRIX_YY = 3'd1;
	localparam logic [RegIdxW-1:0] REG_MATRIX_ZZ = 3'd2;
	localparam logic [RegIdxW-1:0] REG_MATRIX_XY = 3'd3;
	localparam logic [RegIdxW-1:0] REG_MATRIX_XZ = 3'd4;
	localparam logic [RegIdxW-1:0] REG_MATRIX_YZ = 3'd5;
	localparam logic [RegIdxW-1:0] REG_HARD_IRON = 3'd6;

	localparam logic signed [CoefW-1:0] RstMatrixXx = 16'sd17546;
	localparam logic signed [CoefW-1:0] RstMatrixYy = 16'sd16907;
	localparam logic signed [CoefW-1:0] RstMatrixZz = 16'sd16958;
	localparam logic signed [CoefW-1:0] RstMatrixXy = -16'sd90;
	localparam logic signed [CoefW-1:0] RstMatrixXz = -16'sd214;
	localparam logic signed [CoefW-1:0] RstMatrixYz = -16'sd132;
	localparam logic [RegDataW-1:0] RstHardIron = 48'd944892477120;

	typedef struct packed {
		logic signed [CoefW-1:0] mxx;
		logic signed [CoefW-1:0] myy;
		logic signed [CoefW-1:0] mzz;
		logic signed [CoefW-1:0] mxy;
		logic signed [CoefW-1:0] mxz;
		logic signed [CoefW-1:0] myz;
		logic [RawW-1:0] off_x;
		logic [RawW-1:0] off_y;
		logic [RawW-1:0] off_z;
	} cfg_t;

	typedef struct packed {
		logic signed [AccW-1:0] x;
		logic signed [AccW-1:0] y;
		logic signed [AccW-1:0] z;
	} acc_vec_t;

	typedef struct packed {
		logic [OutW-1:0] z;
		logic [OutW-1:0] y;
		logic [OutW-1:0] x;
	} out_vec_t;

endpackage

@@ hw/rtl/mic_cfg.sv @@
// Configuration register file: soft-iron matrix and hard-iron offsets.
// Depends on mic_pkg.
module mic_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mic_pkg::RegIdxW-1:0]    wr_index,
	input  logic [mic_pkg::RegDataW-1:0]   wr_data,
	output mic_pkg::cfg_t                  cfg
);
	import mic_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mxx <= RstMatrixXx;
			cfg_q.myy <= RstMatrixYy;
			cfg_q.mzz <= RstMatrixZz;
			cfg_q.mxy <= RstMatrixXy;
			cfg_q.mxz <= RstMatrixXz;
			cfg_q.myz <= RstMatrixYz;
			cfg_q.off_x <= RstHardIron[RawW-1:0];
			cfg_q.off_y <= RstHardIron[2*RawW-1:RawW];
			cfg_q.off_z <= RstHardIron[3*RawW-1:2*RawW];
		end else if (wr_en) begin
			case (wr_index)
				REG_MATRIX_XX: cfg_q.mxx <= wr_data[CoefW-1:0];
				REG_MATRIX_YY: cfg_q.myy <= wr_data[CoefW-1:0];
				REG_MATRIX_ZZ: cfg_q.mzz <= wr_data[CoefW-1:0];
				REG_MATRIX_XY: cfg_q.mxy <= wr_data[CoefW-1:0];
				REG_MATRIX_XZ: cfg_q.mxz <= wr_data[CoefW-1:0];
				REG_MATRIX_YZ: cfg_q.myz <= wr_data[CoefW-1:0];
				REG_HARD_IRON: begin
					cfg_q.off_x <= wr_data[RawW-1:0];
					cfg_q.off_y <= wr_data[2*RawW-1:RawW];
					cfg_q.off_z <= wr_data[3*RawW-1:2*RawW];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/mic_mac.sv @@
// Offset subtract, nine products and row sums in three pipeline stages.
// Depends on mic_pkg.
module mic_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mic_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mic_pkg::RawW-1:0]    raw_x,
	input  logic [mic_pkg::RawW-1:0]    raw_y,
	input  logic [mic_pkg::RawW-1:0]    raw_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output mic_pkg::acc_vec_t           acc
);
	import mic_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	logic signed [DiffW-1:0] dx, dy, dz;
	logic signed [DiffW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [ProdW-1:0] p_s2 [9];
	acc_vec_t acc_s3;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign dx = $signed({raw_x[RawW-1], raw_x}) - $signed({cfg.off_x[RawW-1], cfg.off_x});
	assign dy = $signed({raw_y[RawW-1], raw_y}) - $signed({cfg.off_y[RawW-1], cfg.off_y});
	assign dz = $signed({raw_z[RawW-1], raw_z}) - $signed({cfg.off_z[RawW-1], cfg.off_z});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dx_s1 <= dx;
			dy_s1 <= dy;
			dz_s1 <= dz;
		end
		if (rdy2 && v_s1) begin
			p_s2[0] <= dx_s1 * cfg.mxx;
			p_s2[1] <= dy_s1 * cfg.mxy;
			p_s2[2] <= dz_s1 * cfg.mxz;
			p_s2[3] <= dx_s1 * cfg.mxy;
			p_s2[4] <= dy_s1 * cfg.myy;
			p_s2[5] <= dz_s1 * cfg.myz;
			p_s2[6] <= dx_s1 * cfg.mxz;
			p_s2[7] <= dy_s1 * cfg.myz;
			p_s2[8] <= dz_s1 * cfg.mzz;
		end
		if (rdy3 && v_s2) begin
			acc_s3.x <= AccW'(p_s2[0]) + AccW'(p_s2[1]) + AccW'(p_s2[2]);
			acc_s3.y <= AccW'(p_s2[3]) + AccW'(p_s2[4]) + AccW'(p_s2[5]);
			acc_s3.z <= AccW'(p_s2[6]) + AccW'(p_s2[7]) + AccW'(p_s2[8]);
		end
	end

	assign out_valid = v_s3;
	assign acc = acc_s3;

endmodule

@@ hw/rtl/mic_scale.sv @@
// Scale by 1/30720 with rounding half away from zero, then saturate.
// Three pipeline stages; the last one is the output register. Depends on mic_pkg.
module mic_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mic_pkg::acc_vec_t    acc,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mic_pkg::out_vec_t    res
);
	import mic_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic rdy4, rdy5, rdy6;
	logic signed [AccW-1:0] acc_in [3];
	logic [2:0] neg_s4, neg_s5;
	logic [QuotW-1:0] t_s4 [3];
	logic [OutW-1:0] q_s5 [3];
	logic [OutW-1:0] r_s6 [3];
	logic [AccW-1:0] mag [3];
	logic [AccW-1:0] biased [3];
	logic [RecipProdW-1:0] rp [3];
	logic [OutW-1:0] sat [3];

	assign rdy6 = !v_s6 || out_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign in_ready = rdy4;

	assign acc_in[0] = acc.x;
	assign acc_in[1] = acc.y;
	assign acc_in[2] = acc.z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = acc_in[i][AccW-1] ? AccW'(-acc_in[i]) : AccW'(acc_in[i]);
			biased[i] = mag[i] + RoundBias;
			rp[i] = RecipProdW'(t_s4[i]) * RecipProdW'(Recip15);
			if (neg_s5[i]) begin
				sat[i] = ({1'b0, q_s5[i]} > OutMinMag) ? OutMinMag[OutW-1:0]
					: OutW'(-{1'b0, q_s5[i]});
			end else begin
				sat[i] = (q_s5[i] > OutMaxMag) ? OutMaxMag : q_s5[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy4) v_s4 <= in_valid;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (rdy4 && in_valid) begin
				neg_s4[i] <= acc_in[i][AccW-1];
				t_s4[i] <= biased[i][ScaleShift+QuotW-1:ScaleShift];
			end
			if (rdy5 && v_s4) begin
				neg_s5[i] <= neg_s4[i];
				q_s5[i] <= rp[i][RecipShift+OutW-1:RecipShift];
			end
			if (rdy6 && v_s5) begin
				r_s6[i] <= sat[i];
			end
		end
	end

	assign out_valid = v_s6;
	assign res.x = r_s6[0];
	assign res.y = r_s6[1];
	assign res.z = r_s6[2];

endmodule

@@ hw/rtl/magnetometer_iron_calibration.sv @@
// Magnetometer hard/soft-iron calibration: register file, product/sum pipe, scaler.
// Depends on mic_pkg, mic_cfg, mic_mac, mic_scale and the assertion macro header.
//
// One three-axis sample per beat, one calibrated beat out per sample. Unless the
// output stalls, the block takes a new beat every cycle; a beat passes six register
// stages (offset subtract, products, row sums, round-bias shift, reciprocal
// multiply, saturation into the output register) on its way to the output.
// Back-pressure from m_axis_tready fills the six stages before s_axis_tready drops.
// Write configuration only while no beat is in flight.
`include "magnetometer_iron_calibration_macros.svh"

module magnetometer_iron_calibration (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [47:0]                    s_axis_tdata,  // raw_x, raw_y, raw_z
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [63:0]                    m_axis_tdata,  // cal_x, cal_y, cal_z, 4'b0
	input  logic                           wr_en,
	input  logic [mic_pkg::RegIdxW-1:0]    wr_index,
	input  logic [mic_pkg::RegDataW-1:0]   wr_data
);
	import mic_pkg::*;

	cfg_t cfg;
	acc_vec_t acc;
	out_vec_t res;
	logic mac_valid, scale_ready;

	mic_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	mic_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.raw_x     (s_axis_tdata[RawW-1:0]),
		.raw_y     (s_axis_tdata[2*RawW-1:RawW]),
		.raw_z     (s_axis_tdata[3*RawW-1:2*RawW]),
		.out_valid (mac_valid),
		.out_ready (scale_ready),
		.acc       (acc)
	);

	mic_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mac_valid),
		.in_ready  (scale_ready),
		.acc       (acc),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {4'b0, res};

	`MIC_ASSERT_IMP(a_stall_from_output, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
	`MIC_ASSERT_IMP(a_inner_stall_from_output, clk, arst_n, mac_valid && !scale_ready, m_axis_tvalid && !m_axis_tready)
	`MIC_ASSERT_IMP(a_empty_out_takes_beat, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`MIC_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule
